@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/ragt_pkg.sv @@
package ragt_pkg;
  localparam int unsigned IDX_W = 11;
  localparam int unsigned DATA_W = 64;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_SEL,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_UP_RD0,
    ST_UP_RD1,
    ST_UP_GCD,
    ST_UP_WAIT,
    ST_FEN_RD,
    ST_FEN_WR,
    ST_Q_PRE_RD,
    ST_Q_PRE_ACC,
    ST_Q_RNG_STEP,
    ST_Q_RNG_RD,
    ST_Q_RNG_GCD,
    ST_Q_RNG_WAIT,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } gcd_req_t;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
    mag = x[DATA_W-1] ? (~x + 64'd1) : x;
  endfunction
endpackage

@@ sv/ragt_gcd.sv @@
module ragt_gcd (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ragt_pkg::gcd_req_t       req,
  output logic                     done,
  output logic [ragt_pkg::DATA_W-1:0] result
);
  import ragt_pkg::*;

  // binary gcd, one step per cycle
  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [6:0] k_r, k_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [DATA_W-1:0] diff;

  assign diff = (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    if (req.start) begin
      a_nxt = req.a;
      b_nxt = req.b;
      k_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r == '0 || b_r == '0) begin
        res_nxt = (a_r | b_r) << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 7'd1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else begin
        a_nxt = (a_r < b_r) ? a_r : b_r;
        b_nxt = diff >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign result = res_r;
endmodule

@@ sv/ragt_mem.sv @@
module ragt_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ragt_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [ragt_pkg::DATA_W-1:0] rdata
);
  import ragt_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/range_add_range_gcd_tree_unit.sv @@
// range add / range gcd unit over NUM_POSITIONS signed 64-bit values
// input: pulse start while busy is low with in_req_type, in_left_index,
//   in_right_index and in_add_value; the transaction is taken at that edge
// an add (in_req_type 0) gives no result; a query gives one result on
//   out_gcd_value, marked by out_valid for exactly one cycle
// the receiver cannot stall; busy stays high until the transaction is done
// each tree node visit runs one binary gcd on a shared gcd unit; a
//   transaction visits about 2*log2(N) nodes
// the gcd tree and the prefix (Fenwick) tree live in two single-port-write
//   memories with registered reads
// reset: a clearing pass writes zero to every entry of both memories,
//   while busy is held high
module range_add_range_gcd_tree_unit #(
  parameter int unsigned NUM_POSITIONS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [ragt_pkg::IDX_W-1:0]    in_left_index,
  input  logic [ragt_pkg::IDX_W-1:0]    in_right_index,
  input  logic signed [ragt_pkg::DATA_W-1:0] in_add_value,
  output logic                          out_valid,
  output logic [ragt_pkg::DATA_W-1:0]   out_gcd_value
);
  import ragt_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned LW = $clog2(NUM_POSITIONS);
  localparam int unsigned TW = LW + 1;
  localparam int unsigned PW = LW + 1;
  localparam int unsigned PD = NUM_POSITIONS + 1;
  localparam int unsigned CW = IDX_W > PW ? IDX_W : PW;
  localparam logic [CW-1:0] NPOS = CW'(NUM_POSITIONS);

  state_t state_r, state_nxt;

  logic [TW-1:0] clr_r, clr_nxt;
  logic req_r, req_nxt;
  logic [CW-1:0] l_r, l_nxt, r_r, r_nxt;
  logic [DATA_W-1:0] v_r, v_nxt;
  logic second_r, second_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [DATA_W-1:0] dv_r, dv_nxt;
  logic [TW-1:0] node_r, node_nxt;
  logic [DATA_W-1:0] lhs_r, lhs_nxt;
  logic [PW-1:0] fi_r, fi_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [TW:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic pick_hi_r, pick_hi_nxt;
  logic [DATA_W-1:0] g_r, g_nxt;
  logic outv_r, outv_nxt;
  logic [DATA_W-1:0] out_r, out_nxt;

  logic g_we, p_we;
  logic [TW-1:0] g_waddr, g_raddr;
  logic [DATA_W-1:0] g_wdata, g_rdata, p_wdata, p_rdata;
  logic [PW-1:0] p_waddr, p_raddr;

  gcd_req_t gq;
  logic gdone;
  logic [DATA_W-1:0] gres;

  ragt_mem #(.DEPTH(2 * NUM_POSITIONS), .AW(TW)) u_gmem (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  ragt_mem #(.DEPTH(PD), .AW(PW)) u_pmem (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  ragt_gcd u_gcd (.clk(clk), .rst_n(rst_n), .req(gq), .done(gdone), .result(gres));

  logic [PW-1:0] fi_low;
  assign fi_low = fi_r & (~fi_r + PW'(1));

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    req_nxt = req_r;
    l_nxt = l_r;
    r_nxt = r_r;
    v_nxt = v_r;
    second_nxt = second_r;
    pos_nxt = pos_r;
    dv_nxt = dv_r;
    node_nxt = node_r;
    lhs_nxt = lhs_r;
    fi_nxt = fi_r;
    acc_nxt = acc_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    pick_hi_nxt = pick_hi_r;
    g_nxt = g_r;
    outv_nxt = 1'b0;
    out_nxt = out_r;
    g_we = 1'b0;
    g_waddr = node_r;
    g_wdata = '0;
    g_raddr = node_r;
    p_we = 1'b0;
    p_waddr = fi_r;
    p_wdata = '0;
    p_raddr = fi_r;
    gq = '0;
    unique case (state_r)
      ST_CLEAR: begin
        g_we = 1'b1;
        g_waddr = clr_r;
        p_we = (32'(clr_r) < PD);
        p_waddr = PW'(clr_r);
        clr_nxt = clr_r + TW'(1);
        if (32'(clr_r) == 2 * NUM_POSITIONS - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req_type;
          l_nxt = CW'(in_left_index);
          r_nxt = CW'(in_right_index);
          v_nxt = in_add_value;
          second_nxt = 1'b0;
          state_nxt = (in_req_type == REQ_ADD) ? ST_ADD_SEL : ST_Q_PRE_RD;
          if (in_req_type == REQ_QUERY) begin
            if (CW'(in_left_index) > NPOS) l_nxt = NPOS;
            if (CW'(in_right_index) > NPOS) r_nxt = NPOS;
          end
        end
      end
      ST_ADD_SEL: begin
        // first pass at left with +v, second at right+1 with -v
        if (!second_r) begin
          pos_nxt = l_r;
          dv_nxt = v_r;
        end else begin
          pos_nxt = r_r + CW'(1);
          dv_nxt = ~v_r + 64'd1;
        end
        if (second_r && r_r >= NPOS) state_nxt = ST_IDLE;
        else if (!second_r && (l_r == '0 || l_r > NPOS)) second_nxt = 1'b1;
        else begin
          node_nxt = TW'(NPOS + (second_r ? r_r + CW'(1) : l_r) - CW'(1));
          state_nxt = ST_LEAF_RD;
        end
      end
      ST_LEAF_RD: begin
        g_raddr = node_r;
        state_nxt = ST_LEAF_WR;
      end
      ST_LEAF_WR: begin
        g_we = 1'b1;
        g_waddr = node_r;
        g_wdata = g_rdata + dv_r;
        node_nxt = node_r >> 1;
        state_nxt = ST_UP_RD0;
      end
      ST_UP_RD0: begin
        g_raddr = {node_r[TW-2:0], 1'b0};
        state_nxt = ST_UP_RD1;
      end
      ST_UP_RD1: begin
        g_raddr = {node_r[TW-2:0], 1'b1};
        lhs_nxt = mag(g_rdata);
        state_nxt = ST_UP_GCD;
      end
      ST_UP_GCD: begin
        gq.start = 1'b1;
        gq.a = lhs_r;
        gq.b = mag(g_rdata);
        state_nxt = ST_UP_WAIT;
      end
      ST_UP_WAIT: begin
        if (gdone) begin
          g_we = 1'b1;
          g_waddr = node_r;
          g_wdata = gres;
          node_nxt = node_r >> 1;
          if (node_r == TW'(1)) begin
            fi_nxt = PW'(pos_r);
            state_nxt = ST_FEN_RD;
          end else state_nxt = ST_UP_RD0;
        end
      end
      ST_FEN_RD: begin
        p_raddr = fi_r;
        state_nxt = ST_FEN_WR;
      end
      ST_FEN_WR: begin
        p_we = 1'b1;
        p_waddr = fi_r;
        p_wdata = p_rdata + dv_r;
        fi_nxt = fi_r + fi_low;
        if ((CW'(fi_r) + CW'(fi_low)) > NPOS || (fi_r + fi_low) == '0) begin
          if (second_r) state_nxt = ST_IDLE;
          else begin
            second_nxt = 1'b1;
            state_nxt = ST_ADD_SEL;
          end
        end else state_nxt = ST_FEN_RD;
      end
      ST_Q_PRE_RD: begin
        acc_nxt = '0;
        fi_nxt = PW'(l_r);
        if (l_r == '0) state_nxt = ST_Q_PRE_ACC;
        else begin
          p_raddr = PW'(l_r);
          state_nxt = ST_Q_PRE_ACC;
        end
      end
      ST_Q_PRE_ACC: begin
        if (fi_r == '0) begin
          g_nxt = mag(acc_r);
          lo_nxt = (TW+1)'(l_r) + (TW+1)'(NPOS);
          hi_nxt = (TW+1)'(r_r) + (TW+1)'(NPOS);
          state_nxt = (l_r + CW'(1) <= r_r) ? ST_Q_RNG_STEP : ST_Q_DONE;
        end else begin
          acc_nxt = acc_r + p_rdata;
          fi_nxt = fi_r - fi_low;
          p_raddr = fi_r - fi_low;
        end
      end
      ST_Q_RNG_STEP: begin
        if (lo_r >= hi_r) state_nxt = ST_Q_DONE;
        else if (lo_r[0]) begin
          g_raddr = lo_r[TW-1:0];
          pick_hi_nxt = 1'b0;
          lo_nxt = lo_r + 1'b1;
          state_nxt = ST_Q_RNG_RD;
        end else if (hi_r[0]) begin
          g_raddr = hi_r[TW-1:0] - TW'(1);
          pick_hi_nxt = 1'b1;
          hi_nxt = hi_r - 1'b1;
          state_nxt = ST_Q_RNG_RD;
        end else begin
          lo_nxt = lo_r >> 1;
          hi_nxt = hi_r >> 1;
        end
      end
      ST_Q_RNG_RD: begin
        gq.start = 1'b1;
        gq.a = g_r;
        gq.b = mag(g_rdata);
        state_nxt = ST_Q_RNG_WAIT;
      end
      ST_Q_RNG_WAIT: begin
        if (gdone) begin
          g_nxt = gres;
          // both ends odd at one level: hi handled next, then halve
          if (!pick_hi_r && hi_r[0]) begin
            state_nxt = ST_Q_RNG_STEP;
          end else begin
            lo_nxt = lo_r >> 1;
            hi_nxt = hi_r >> 1;
            state_nxt = ST_Q_RNG_STEP;
          end
          if (!pick_hi_r && hi_r[0]) begin
            g_raddr = hi_r[TW-1:0] - TW'(1);
            pick_hi_nxt = 1'b1;
            hi_nxt = hi_r - 1'b1;
            state_nxt = ST_Q_RNG_RD;
          end
        end
      end
      ST_Q_DONE: begin
        outv_nxt = 1'b1;
        out_nxt = g_r;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      outv_r <= outv_nxt;
    end
    req_r <= req_nxt;
    l_r <= l_nxt;
    r_r <= r_nxt;
    v_r <= v_nxt;
    second_r <= second_nxt;
    pos_r <= pos_nxt;
    dv_r <= dv_nxt;
    node_r <= node_nxt;
    lhs_r <= lhs_nxt;
    fi_r <= fi_nxt;
    acc_r <= acc_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    pick_hi_r <= pick_hi_nxt;
    g_r <= g_nxt;
    out_r <= out_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = outv_r;
  assign out_gcd_value = out_r;

  `ASSERT_NEXT(a_result_from_query, clk, rst_n, state_r == ST_Q_DONE, out_valid)
  `ASSERT_IMPL(a_result_only_query, clk, rst_n, out_valid, req_r == REQ_QUERY)
  `ASSERT_IMPL(a_no_write_in_query, clk, rst_n,
    state_r == ST_Q_RNG_STEP || state_r == ST_Q_PRE_ACC, !g_we && !p_we)
endmodule
